// ===== hdl/pic_pkg.sv =====
// shared types, register indexes and constants for the pulse irrigation controller
package pic_pkg;

   localparam int unsigned MAX_PULSES = 5;

   // (4095 - soil_raw) * 100 / 2595 by reciprocal: 100 * ceil(2^32 / 2595)
   localparam int unsigned SOIL_SHIFT = 32;
   localparam logic [27:0] SOIL_K = 28'd165509400;
   localparam logic [6:0]  PCT_MAX = 7'd100;

   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_TARGET     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_NORM = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_HOT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HOT_TEMP   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DRY_HUM    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BRIGHT     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_PUMP_MS    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SOAK_MS    = 3'd7;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_PUMP  = 2'd1,
      PH_SOAK  = 2'd2,
      PH_FAULT = 2'd3
   } phase_type;

   typedef struct packed {
      logic [6:0]  target_percent;
      logic [6:0]  start_percent_normal;
      logic [6:0]  start_percent_hot;
      logic [10:0] hot_temp_tenths;
      logic [9:0]  dry_humidity_tenths;
      logic [11:0] bright_limit;
      logic [15:0] pump_ms;
      logic [15:0] soak_ms;
   } cfg_type;

   typedef struct packed {
      logic [6:0]  soil_percent;
      logic        start_dry;
      logic        hot_boost;
      logic        rain_soon;
      logic        auto_mode;
      logic [31:0] now_ms;
   } tick_type;

   typedef struct packed {
      logic        pump_on;
      logic        fault_flag;
      logic [1:0]  phase;
      logic [3:0]  cycle_count;
      logic [6:0]  soil_percent;
      logic        hot_boost;
   } rsp_type;

endpackage

// ===== hdl/pic_csr.sv =====
// configuration register file
module pic_csr import pic_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_TARGET:     cfg_in.target_percent       = csr_data[6:0];
            CSR_START_NORM: cfg_in.start_percent_normal = csr_data[6:0];
            CSR_START_HOT:  cfg_in.start_percent_hot    = csr_data[6:0];
            CSR_HOT_TEMP:   cfg_in.hot_temp_tenths      = csr_data[10:0];
            CSR_DRY_HUM:    cfg_in.dry_humidity_tenths  = csr_data[9:0];
            CSR_BRIGHT:     cfg_in.bright_limit         = csr_data[11:0];
            CSR_PUMP_MS:    cfg_in.pump_ms              = csr_data;
            CSR_SOAK_MS:    cfg_in.soak_ms              = csr_data;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_percent       <= 7'd60;
         cfg_ff.start_percent_normal <= 7'd40;
         cfg_ff.start_percent_hot    <= 7'd55;
         cfg_ff.hot_temp_tenths      <= 11'd320;
         cfg_ff.dry_humidity_tenths  <= 10'd500;
         cfg_ff.bright_limit         <= 12'd2000;
         cfg_ff.pump_ms              <= 16'd5000;
         cfg_ff.soak_ms              <= 16'd5000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hdl/pic_cond.sv =====
// input stage: soil percent, weather boost and start decision, registered per beat
module pic_cond import pic_pkg::*; (
   input  logic               clock,
   input  logic               load,
   input  cfg_type            cfg,
   input  logic [11:0]        soil_raw,
   input  logic signed [10:0] temp_tenths,
   input  logic [9:0]         humidity_tenths,
   input  logic               sensor_valid,
   input  logic [11:0]        light_raw,
   input  logic               rain_soon,
   input  logic               auto_mode,
   input  logic [31:0]        now_ms,
   output tick_type           tick
);

   tick_type    tick_ff;
   tick_type    tick_in;
   logic [11:0] dry_span;
   logic [39:0] pct_prod;
   logic [7:0]  pct_raw;
   logic [6:0]  pct;
   logic signed [10:0] temp_eff;
   logic [9:0]  hum_eff;
   logic        hot;

   assign tick = tick_ff;

   always_comb begin
      dry_span = ~soil_raw;
      pct_prod = {28'd0, dry_span} * {12'd0, SOIL_K};
      pct_raw  = pct_prod[SOIL_SHIFT+7:SOIL_SHIFT];
      pct      = (pct_raw > {1'b0, PCT_MAX}) ? PCT_MAX : pct_raw[6:0];
      temp_eff = sensor_valid ? temp_tenths : 11'sd0;
      hum_eff  = sensor_valid ? humidity_tenths : 10'd0;
      hot = (temp_eff > $signed(cfg.hot_temp_tenths)) &&
            (hum_eff < cfg.dry_humidity_tenths) &&
            (light_raw < cfg.bright_limit);
      tick_in.soil_percent = pct;
      tick_in.hot_boost    = hot;
      tick_in.start_dry    = hot ? (pct < cfg.start_percent_hot)
                                 : (pct < cfg.start_percent_normal);
      tick_in.rain_soon    = rain_soon;
      tick_in.auto_mode    = auto_mode;
      tick_in.now_ms       = now_ms;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         tick_ff <= tick_in;
      end
   end

endmodule

// ===== hdl/pic_seq.sv =====
// pulse sequencer state and result register
module pic_seq import pic_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  cfg_type  cfg,
   input  tick_type tick,
   output rsp_type  rsp
);

   phase_type   phase_ff, phase_in;
   logic [3:0]  count_ff, count_in;
   logic [31:0] start_ms_ff, start_ms_in;
   logic        fault_ff, fault_in;
   rsp_type     rsp_ff, rsp_in;
   logic [31:0] elapsed;
   logic        wet;

   assign rsp = rsp_ff;

   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      start_ms_in = start_ms_ff;
      fault_in    = fault_ff;
      elapsed     = tick.now_ms - start_ms_ff;
      wet         = tick.soil_percent >= cfg.target_percent;
      if (!tick.auto_mode) begin
         phase_in = PH_IDLE;
         count_in = 4'd0;
         fault_in = 1'b0;
      end else if (tick.rain_soon) begin
         if (phase_ff == PH_PUMP) begin
            phase_in = PH_IDLE;
         end
      end else if (wet) begin
         if (phase_ff != PH_IDLE) begin
            phase_in = PH_IDLE;
            count_in = 4'd0;
         end
      end else begin
         case (phase_ff)
            PH_FAULT: begin
               fault_in = 1'b1;
            end
            PH_IDLE: begin
               if (tick.start_dry) begin
                  phase_in    = PH_PUMP;
                  count_in    = 4'd1;
                  start_ms_in = tick.now_ms;
               end
            end
            PH_PUMP: begin
               if (elapsed >= {16'd0, cfg.pump_ms}) begin
                  phase_in    = PH_SOAK;
                  start_ms_in = tick.now_ms;
               end
            end
            PH_SOAK: begin
               if (elapsed >= {16'd0, cfg.soak_ms}) begin
                  if (count_ff >= 4'(MAX_PULSES)) begin
                     phase_in = PH_FAULT;
                     fault_in = 1'b1;
                  end else begin
                     phase_in    = PH_PUMP;
                     count_in    = count_ff + 4'd1;
                     start_ms_in = tick.now_ms;
                  end
               end
            end
            default: phase_in = phase_ff;
         endcase
      end
      rsp_in.pump_on      = phase_in == PH_PUMP;
      rsp_in.fault_flag   = fault_in;
      rsp_in.phase        = phase_in;
      rsp_in.cycle_count  = count_in;
      rsp_in.soil_percent = tick.soil_percent;
      rsp_in.hot_boost    = tick.hot_boost;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         count_ff    <= 4'd0;
         start_ms_ff <= 32'd0;
         fault_ff    <= 1'b0;
      end else if (advance) begin
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         start_ms_ff <= start_ms_in;
         fault_ff    <= fault_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ===== hdl/pulse_irrigation_controller_core.sv =====
// top level of the pulse irrigation controller
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  one control tick
//   rsp      out        rsp_valid/rsp_stall  relay, phase, count, percent, boost
//   csr      in         csr_valid/csr_ready  register index and data
//
// one tick per clock while the result is not stalled; input register then result register
// the conversion multiplier sits before the input register, the sequencer after it
// reset clears the sequencer state, the valid flags and the config registers to defaults
// a stalled result holds, as does a full input stage; req_stall rises only while s1 is full
module pulse_irrigation_controller_core import pic_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [11:0]           req_soil_raw,
   input  logic signed [10:0]    req_temp_tenths,
   input  logic [9:0]            req_humidity_tenths,
   input  logic                  req_sensor_valid,
   input  logic [11:0]           req_light_raw,
   input  logic                  req_rain_soon,
   input  logic                  req_auto_mode,
   input  logic [31:0]           req_now_ms,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_pump_on,
   output logic                  rsp_fault_flag,
   output logic [1:0]            rsp_phase,
   output logic [3:0]            rsp_cycle_count,
   output logic [6:0]            rsp_soil_percent,
   output logic                  rsp_hot_boost,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type  cfg;
   tick_type tick;
   rsp_type  rsp;
   logic     s1_valid_ff, s1_valid_in;
   logic     rsp_valid_ff, rsp_valid_in;
   logic     out_free, s1_adv, req_acc;

   always_comb begin
      out_free     = !rsp_valid_ff || !rsp_stall;
      s1_adv       = s1_valid_ff && out_free;
      req_stall    = s1_valid_ff && !out_free;
      req_acc      = req_valid && !req_stall;
      s1_valid_in  = req_acc || (s1_valid_ff && !s1_adv);
      rsp_valid_in = s1_adv || (rsp_valid_ff && !out_free);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   pic_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   pic_cond u_cond (
      .clock           (clock),
      .load            (req_acc),
      .cfg             (cfg),
      .soil_raw        (req_soil_raw),
      .temp_tenths     (req_temp_tenths),
      .humidity_tenths (req_humidity_tenths),
      .sensor_valid    (req_sensor_valid),
      .light_raw       (req_light_raw),
      .rain_soon       (req_rain_soon),
      .auto_mode       (req_auto_mode),
      .now_ms          (req_now_ms),
      .tick            (tick)
   );

   pic_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .advance (s1_adv),
      .cfg     (cfg),
      .tick    (tick),
      .rsp     (rsp)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pump_on      = rsp.pump_on;
   assign rsp_fault_flag   = rsp.fault_flag;
   assign rsp_phase        = rsp.phase;
   assign rsp_cycle_count  = rsp.cycle_count;
   assign rsp_soil_percent = rsp.soil_percent;
   assign rsp_hot_boost    = rsp.hot_boost;

endmodule

// ===== hdl/pic_checker.sv =====
// port-level checks for the pulse irrigation controller, bound to the top level
module pic_checker import pic_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic                  rsp_pump_on,
   input logic                  rsp_fault_flag,
   input logic [1:0]            rsp_phase,
   input logic [3:0]            rsp_cycle_count,
   input logic [6:0]            rsp_soil_percent,
   input logic                  rsp_hot_boost
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_phase) &&
         $stable(rsp_cycle_count) && $stable(rsp_soil_percent) &&
         $stable(rsp_fault_flag) && $stable(rsp_hot_boost))
      else $error("stalled result beat changed");

   a_relay_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pump_on == (rsp_phase == PH_PUMP))
      else $error("relay does not follow pumping phase");

   a_fault_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_phase == PH_FAULT |-> rsp_fault_flag)
      else $error("fault phase without fault flag");

   a_pump_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_phase != PH_IDLE |-> rsp_cycle_count != 4'd0 &&
         rsp_soil_percent <= PCT_MAX)
      else $error("active run without pulse count or percent out of range");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

endmodule

bind pulse_irrigation_controller_core pic_checker u_pic_checker (.*);
